// ===== rtl/ext2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ext2d_pkg
// Types and constants shared by the ext2 directory record parser.
// ----------------------------------------------------------------------------
package ext2d_pkg;

  // Fixed part of a directory record: inode, rec_len, name length, file type
  localparam int unsigned BaseSize = 8;

  localparam int unsigned PosW = 17;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_PAD    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] entry_inode;
    logic [15:0] record_length;
    logic [7:0]  name_length;
    logic [7:0]  entry_type;
    logic [7:0]  name_char;
    logic        name_end;
    logic        dir_end;
    logic        truncated;
  } result_t;

endpackage

// ===== rtl/ext2d_parse.sv =====
// ----------------------------------------------------------------------------
// ext2d_parse
// Record state and per-byte decode: header capture, name walk, padding skip.
// ----------------------------------------------------------------------------
module ext2d_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                emit_o,
  output ext2d_pkg::result_t  result_o
);

  ext2d_pkg::phase_e                 phase_q, phase_d, phase_n;
  logic [ext2d_pkg::PosW-1:0]        pos_q, pos_d, pos_n, pos_inc;
  logic [31:0]                       inode_q, inode_d, inode_n;
  logic [15:0]                       rec_len_q, rec_len_d, rec_len_n;
  logic [7:0]                        nlen_q, nlen_d, nlen_n;
  logic [7:0]                        type_q, type_d, type_n;
  logic [2:0]                        hdr_idx;
  logic [8:0]                        end_pos;
  logic                              emit, nend, trunc;
  ext2d_pkg::kind_e                  kind;

  assign pos_inc = pos_q + ext2d_pkg::PosW'(1);
  assign hdr_idx = pos_q[2:0];
  assign end_pos = 9'(ext2d_pkg::BaseSize) + {1'b0, nlen_q};

  always_comb begin
    phase_n   = phase_q;
    pos_n     = pos_q;
    inode_n   = inode_q;
    rec_len_n = rec_len_q;
    nlen_n    = nlen_q;
    type_n    = type_q;
    emit      = 1'b0;
    kind      = ext2d_pkg::KIND_END;
    nend      = 1'b0;
    trunc     = 1'b0;
    unique case (phase_q)
      ext2d_pkg::PH_NAME: begin
        emit  = 1'b1;
        kind  = ext2d_pkg::KIND_NAME;
        pos_n = pos_inc;
        nend  = (pos_inc >= {8'd0, end_pos});
        if (nend) begin
          if ({1'b0, rec_len_q} > {8'd0, end_pos}) begin
            phase_n = ext2d_pkg::PH_PAD;
          end else begin
            phase_n = ext2d_pkg::PH_HEADER;
            pos_n   = '0;
          end
        end else begin
          trunc = last_byte_i;
        end
      end
      ext2d_pkg::PH_PAD: begin
        pos_n = pos_inc;
        if (pos_inc >= {1'b0, rec_len_q}) begin
          phase_n = ext2d_pkg::PH_HEADER;
          pos_n   = '0;
        end
      end
      default: begin
        // header phase; little-endian field capture by byte position
        phase_n = ext2d_pkg::PH_HEADER;
        unique case (hdr_idx)
          3'd0: inode_n[7:0]     = data_byte_i;
          3'd1: inode_n[15:8]    = data_byte_i;
          3'd2: inode_n[23:16]   = data_byte_i;
          3'd3: inode_n[31:24]   = data_byte_i;
          3'd4: rec_len_n[7:0]   = data_byte_i;
          3'd5: rec_len_n[15:8]  = data_byte_i;
          3'd6: nlen_n           = data_byte_i;
          default: type_n        = data_byte_i;
        endcase
        pos_n = {{(ext2d_pkg::PosW-3){1'b0}}, hdr_idx} + ext2d_pkg::PosW'(1);
        if (hdr_idx == 3'd7) begin
          emit = 1'b1;
          kind = ext2d_pkg::KIND_HEADER;
          nend = (nlen_n == 8'd0);
          if (nlen_n != 8'd0) begin
            phase_n = ext2d_pkg::PH_NAME;
            trunc   = last_byte_i;
          end else if (rec_len_n > 16'(ext2d_pkg::BaseSize)) begin
            phase_n = ext2d_pkg::PH_PAD;
          end else begin
            pos_n = '0;
          end
        end else begin
          trunc = last_byte_i;
        end
      end
    endcase
  end

  // last byte of the directory returns everything to reset values
  always_comb begin
    if (last_byte_i) begin
      phase_d   = ext2d_pkg::PH_HEADER;
      pos_d     = '0;
      inode_d   = '0;
      rec_len_d = '0;
      nlen_d    = '0;
      type_d    = '0;
    end else begin
      phase_d   = phase_n;
      pos_d     = pos_n;
      inode_d   = inode_n;
      rec_len_d = rec_len_n;
      nlen_d    = nlen_n;
      type_d    = type_n;
    end
  end

  always_comb begin
    emit_o             = emit | last_byte_i;
    result_o.kind      = kind;
    result_o.dir_end   = last_byte_i;
    result_o.truncated = trunc;
    if (kind == ext2d_pkg::KIND_END) begin
      result_o.entry_inode   = '0;
      result_o.record_length = '0;
      result_o.name_length   = '0;
      result_o.entry_type    = '0;
      result_o.name_char     = '0;
      result_o.name_end      = 1'b0;
    end else begin
      result_o.entry_inode   = inode_n;
      result_o.record_length = rec_len_n;
      result_o.name_length   = nlen_n;
      result_o.entry_type    = type_n;
      result_o.name_char     = (kind == ext2d_pkg::KIND_NAME) ? data_byte_i : 8'd0;
      result_o.name_end      = nend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ext2d_pkg::PH_HEADER;
      pos_q     <= '0;
      inode_q   <= '0;
      rec_len_q <= '0;
      nlen_q    <= '0;
      type_q    <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      inode_q   <= inode_d;
      rec_len_q <= rec_len_d;
      nlen_q    <= nlen_d;
      type_q    <= type_d;
    end
  end

endmodule

// ===== rtl/ext2d_out_reg.sv =====
// ----------------------------------------------------------------------------
// ext2d_out_reg
// Result register with valid/ready handshake towards the consumer.
// ----------------------------------------------------------------------------
module ext2d_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ext2d_pkg::result_t  word_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ext2d_pkg::result_t  word_o
);

  logic               valid_q, valid_d;
  ext2d_pkg::result_t word_q;

  // free when empty or the held word leaves this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? push_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/ext2_dir_record_parser_top.sv =====
// Output: each result is registered and appears in the cycle after its byte is taken.
// Throughput: one byte per cycle; the single result register stalls input
// only while a held word is not taken.
// Reset: rst_ni (async, active low) clears record state and the result valid.
// The last byte of a directory also returns the record state to reset values.
// ----------------------------------------------------------------------------
// ext2_dir_record_parser_top
// Byte-wise ext2 directory record parser: header, name bytes, end marker.
// ----------------------------------------------------------------------------
module ext2_dir_record_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] entry_inode_o,
  output logic [15:0] record_length_o,
  output logic [7:0]  name_length_o,
  output logic [7:0]  entry_type_o,
  output logic [7:0]  name_char_o,
  output logic        name_end_o,
  output logic        dir_end_o,
  output logic        truncated_o
);

  logic               take, emit;
  ext2d_pkg::result_t res, res_q;

  assign take = in_valid_i && in_ready_o;

  ext2d_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .emit_o      (emit),
    .result_o    (res)
  );

  ext2d_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && emit),
    .word_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (res_q)
  );

  assign kind_o          = res_q.kind;
  assign entry_inode_o   = res_q.entry_inode;
  assign record_length_o = res_q.record_length;
  assign name_length_o   = res_q.name_length;
  assign entry_type_o    = res_q.entry_type;
  assign name_char_o     = res_q.name_char;
  assign name_end_o      = res_q.name_end;
  assign dir_end_o       = res_q.dir_end;
  assign truncated_o     = res_q.truncated;

endmodule
